### rtl/peak_to_peak_sound_level_top_assert.svh
// Assertion macros shared by the checker of the peak-to-peak sound level meter.
// The enclosing module must provide signals named clock and reset.
`ifndef PEAK_TO_PEAK_SOUND_LEVEL_TOP_ASSERT_SVH
`define PEAK_TO_PEAK_SOUND_LEVEL_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define PPSL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked at every clock edge, reset included.
`define PPSL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/ppsl_pkg.sv
// Shared types and constants of the peak-to-peak sound level meter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ppsl_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int TIME_BITS_DEF   = 32;

   localparam int CAL_BITS        = 10;
   localparam int SENS_BITS       = 15;
   localparam int SENS_TERM_BITS  = SENS_BITS + 2;
   localparam int INTERVAL_BITS   = 32;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 3;

   localparam int PCT_BITS        = 14;
   localparam int DB_BITS         = 15;

   localparam int FRAC_BITS       = 24;
   localparam int MANT_BITS       = 31;
   // The top quotient bit flags a percentage of 16384 or more.
   localparam int QUOT_BITS       = 15;
   localparam int CNT_BITS        = 5;
   localparam int DB_SHIFT        = 40;

   localparam int SENS_FULL       = 10000;
   localparam int SENS_OFFSET     = 1000;
   localparam int RANGE_SCALE     = 9000;

   localparam logic [26:0]          PCT_SCALE = 27'd90000000;
   localparam logic [26:0]          DB_K      = 27'd72008302;
   localparam logic [PCT_BITS-1:0]  PCT_MAX   = 14'd10000;
   localparam logic [DB_BITS-1:0]   DB_MAX    = 15'd32767;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_CAL_MODE = 3'd0,
      CSR_CAL_LOW  = 3'd1,
      CSR_CAL_HIGH = 3'd2,
      CSR_SENS     = 3'd3,
      CSR_INTERVAL = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_RNUM,
      ST_PREP,
      ST_DIV,
      ST_NORM_NUM,
      ST_SQ_NUM,
      ST_LOAD_DEN,
      ST_NORM_DEN,
      ST_SQ_DEN,
      ST_DIFF,
      ST_DBMUL,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL,
      OP_RNUM,
      OP_PREP,
      OP_DIV_STEP,
      OP_NORM_STEP,
      OP_MANT,
      OP_SQ_STEP,
      OP_LOAD_DEN,
      OP_DIFF,
      OP_DBMUL,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic   accept;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic publish;
      logic norm_done;
      logic out_busy;
   } status_type;

endpackage

### rtl/ppsl_ctrl.sv
// Controller of the sound level meter: sequences the datapath through a window close.
// Depends on ppsl_pkg for the state, command and status types.
module ppsl_ctrl import ppsl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.accept = 1'b0;
      cmd.op     = OP_NONE;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.publish) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_RNUM;
         end
         ST_RNUM: begin
            cmd.op   = OP_RNUM;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.op   = OP_PREP;
            cnt_in   = CNT_BITS'(QUOT_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_NORM_NUM;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_NORM_NUM: begin
            if (status.norm_done) begin
               cmd.op   = OP_MANT;
               cnt_in   = CNT_BITS'(FRAC_BITS - 1);
               state_in = ST_SQ_NUM;
            end else begin
               cmd.op = OP_NORM_STEP;
            end
         end
         ST_SQ_NUM: begin
            cmd.op = OP_SQ_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_LOAD_DEN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_LOAD_DEN: begin
            cmd.op   = OP_LOAD_DEN;
            state_in = ST_NORM_DEN;
         end
         ST_NORM_DEN: begin
            if (status.norm_done) begin
               cmd.op   = OP_MANT;
               cnt_in   = CNT_BITS'(FRAC_BITS - 1);
               state_in = ST_SQ_DEN;
            end else begin
               cmd.op = OP_NORM_STEP;
            end
         end
         ST_SQ_DEN: begin
            cmd.op = OP_SQ_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_DIFF;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_DBMUL;
         end
         ST_DBMUL: begin
            cmd.op   = OP_DBMUL;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // The result register must be free or emptying this cycle.
            if (!status.out_busy) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/ppsl_dp.sv
// Datapath of the sound level meter: window tracking, hold, divider, log2 unit.
// Depends on ppsl_pkg; driven by ppsl_ctrl through command and status structs.
module ppsl_dp import ppsl_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic                     window_last,
   input  logic [TIME_BITS-1:0]     now_ms,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [SAMPLE_BITS-1:0]   rsp_high,
   output logic [SAMPLE_BITS-1:0]   rsp_low,
   output logic [PCT_BITS-1:0]      rsp_pct,
   output logic [DB_BITS-1:0]       rsp_db
);

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam int BASE_BITS = (SAMPLE_BITS > CAL_BITS) ? SAMPLE_BITS : CAL_BITS;
   localparam int D_W       = BASE_BITS + 2;
   localparam int MUL_W     = D_W + SENS_TERM_BITS;
   // An inverted calibrated span at the top sensitivity code gives the largest range.
   localparam int R_W       = BASE_BITS + 15;
   localparam int PNUM_W    = SAMPLE_BITS + 28;
   localparam int DS_W      = R_W + QUOT_BITS - 1;
   localparam int CMP_W     = (PNUM_W > DS_W) ? PNUM_W : DS_W;
   localparam int C2_W      = SAMPLE_BITS + 15;
   localparam int AD_W      = SAMPLE_BITS + C2_W;
   localparam int L_W       = 2 * SAMPLE_BITS + 16;
   localparam int E_W       = $clog2(L_W);
   localparam int LOG_W     = E_W + FRAC_BITS;
   localparam int P_W       = LOG_W + 27;
   localparam int T_W       = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
   // (2 * full scale - 3) * 9000, the amplitude weight of the dB numerator.
   localparam logic [C2_W-1:0] DB_COEF =
      C2_W'((64'd2 * (64'd1 << SAMPLE_BITS) - 64'd5) * 64'(RANGE_SCALE));

   // Configuration registers.
   logic                     cal_mode_ff;
   logic [CAL_BITS-1:0]      cal_low_ff, cal_high_ff;
   logic [SENS_BITS-1:0]     sens_ff;
   logic [INTERVAL_BITS-1:0] interval_ff;

   // Window and hold state.
   logic [SAMPLE_BITS-1:0]   win_high_ff, win_low_ff;
   logic [SAMPLE_BITS-1:0]   held_amp_ff, held_high_ff, held_low_ff;
   logic [TIME_BITS-1:0]     last_pub_ff;

   // Snapshot of the published hold.
   logic [SAMPLE_BITS-1:0]   amp_ff, snap_high_ff, snap_low_ff;

   // Arithmetic registers.
   logic signed [MUL_W-1:0]  range_prod_ff;
   logic [PNUM_W-1:0]        amp_pct_ff;
   logic [AD_W-1:0]          amp_db_ff;
   logic [R_W-1:0]           rnum_ff;
   logic [CMP_W-1:0]         rem_ff, dsr_ff;
   logic [QUOT_BITS-1:0]     q_ff;
   logic [L_W-1:0]           v_ff;
   logic [E_W-1:0]           e_ff;
   logic [MANT_BITS-1:0]     m_ff;
   logic [FRAC_BITS-1:0]     f_ff;
   logic [LOG_W-1:0]         log_a_ff, l_ff;
   logic [P_W-1:0]           prod_ff;
   logic                     rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]   rsp_high_ff, rsp_low_ff;
   logic [PCT_BITS-1:0]      rsp_pct_ff;
   logic [DB_BITS-1:0]       rsp_db_ff;

   // Combinational terms.
   logic [SAMPLE_BITS-1:0]   hi_new, lo_new, win_amp, h_amp, h_high, h_low;
   logic                     take_window;
   logic [TIME_BITS-1:0]     elapsed;
   logic                     publish;
   logic [BASE_BITS-1:0]     base_hi, base_lo;
   logic signed [D_W-1:0]    range_d;
   logic signed [SENS_TERM_BITS-1:0] sens_term;
   logic signed [MUL_W-1:0]  range_mul;
   logic signed [MUL_W:0]    rnum_raw;
   logic [R_W-1:0]           rnum_in;
   logic [L_W-1:0]           log_num, log_den;
   logic                     rem_ge;
   logic [2*MANT_BITS-1:0]   sq;
   logic [MANT_BITS:0]       sq_top;
   logic signed [LOG_W:0]    log_diff;
   logic [P_W:0]             db_sum;
   logic [P_W-DB_SHIFT:0]    db_sh;
   logic [DB_BITS-1:0]       db_val;
   logic [PCT_BITS-1:0]      pct_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_mode_ff <= 1'b0;
         cal_low_ff  <= '0;
         cal_high_ff <= '1;
         sens_ff     <= SENS_BITS'(5000);
         interval_ff <= INTERVAL_BITS'(1000);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CAL_MODE: cal_mode_ff <= csr_wdata[0];
            CSR_CAL_LOW:  cal_low_ff  <= csr_wdata[CAL_BITS-1:0];
            CSR_CAL_HIGH: cal_high_ff <= csr_wdata[CAL_BITS-1:0];
            CSR_SENS:     sens_ff     <= csr_wdata[SENS_BITS-1:0];
            CSR_INTERVAL: interval_ff <= csr_wdata[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Window fold and hold decision for the word being accepted.
   always_comb begin
      hi_new      = (sample > win_high_ff) ? sample : win_high_ff;
      lo_new      = (sample < win_low_ff) ? sample : win_low_ff;
      win_amp     = hi_new - lo_new;
      take_window = win_amp > held_amp_ff;
      h_amp       = take_window ? win_amp : held_amp_ff;
      h_high      = take_window ? hi_new : held_high_ff;
      h_low       = take_window ? lo_new : held_low_ff;
      elapsed     = now_ms - last_pub_ff;
      publish     = window_last && (T_W'(elapsed) >= T_W'(interval_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_high_ff  <= '0;
         win_low_ff   <= SAMPLE_MAX;
         held_amp_ff  <= '0;
         held_high_ff <= '0;
         held_low_ff  <= SAMPLE_MAX;
         last_pub_ff  <= '0;
      end else if (cmd.accept) begin
         if (!window_last) begin
            win_high_ff <= hi_new;
            win_low_ff  <= lo_new;
         end else begin
            win_high_ff <= '0;
            win_low_ff  <= SAMPLE_MAX;
            if (publish) begin
               last_pub_ff  <= now_ms;
               held_amp_ff  <= '0;
               held_high_ff <= '0;
               held_low_ff  <= SAMPLE_MAX;
            end else begin
               held_amp_ff  <= h_amp;
               held_high_ff <= h_high;
               held_low_ff  <= h_low;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && publish) begin
         amp_ff       <= h_amp;
         snap_high_ff <= h_high;
         snap_low_ff  <= h_low;
      end
   end

   // Scaled range R times 9000, never below 9000.
   always_comb begin
      base_hi   = cal_mode_ff ? BASE_BITS'(cal_high_ff) : BASE_BITS'(SAMPLE_MAX);
      base_lo   = cal_mode_ff ? BASE_BITS'(cal_low_ff) : '0;
      range_d   = $signed(D_W'(base_hi)) - $signed(D_W'(base_lo));
      sens_term = $signed(SENS_TERM_BITS'(SENS_FULL)) - $signed(SENS_TERM_BITS'(sens_ff));
      range_mul = range_d * sens_term;
      rnum_raw  = (MUL_W+1)'(range_prod_ff) + $signed((MUL_W+1)'(sens_ff))
                  - $signed((MUL_W+1)'(SENS_OFFSET));
      rnum_in   = (rnum_raw < $signed((MUL_W+1)'(RANGE_SCALE))) ?
                  R_W'(RANGE_SCALE) : R_W'(rnum_raw);
      log_num   = L_W'(rnum_ff) + (L_W'(rnum_ff) << 1) + L_W'(amp_db_ff);
      log_den   = L_W'(rnum_ff) << 1;
      rem_ge    = rem_ff >= dsr_ff;
      sq        = (2*MANT_BITS)'(m_ff) * (2*MANT_BITS)'(m_ff);
      sq_top    = sq[2*MANT_BITS-1:MANT_BITS-1];
      log_diff  = $signed({1'b0, log_a_ff}) - $signed({1'b0, e_ff, f_ff});
      db_sum    = (P_W+1)'(prod_ff) + ((P_W+1)'(1) << (DB_SHIFT - 1));
      db_sh     = db_sum[P_W:DB_SHIFT];
      db_val    = (db_sh > (P_W-DB_SHIFT+1)'(DB_MAX)) ? DB_MAX : db_sh[DB_BITS-1:0];
      if (q_ff[QUOT_BITS-1] || (q_ff[QUOT_BITS-2:0] > PCT_MAX)) begin
         pct_val = PCT_MAX;
      end else begin
         pct_val = q_ff[QUOT_BITS-2:0];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_MUL: begin
            range_prod_ff <= range_mul;
            amp_pct_ff    <= PNUM_W'(amp_ff) * PNUM_W'(PCT_SCALE);
            amp_db_ff     <= AD_W'(amp_ff) * AD_W'(DB_COEF);
         end
         OP_RNUM: begin
            rnum_ff <= rnum_in;
         end
         OP_PREP: begin
            rem_ff <= CMP_W'(amp_pct_ff) + CMP_W'(rnum_ff >> 1);
            dsr_ff <= CMP_W'(rnum_ff) << (QUOT_BITS - 1);
            q_ff   <= '0;
            v_ff   <= (log_num == '0) ? L_W'(1) : log_num;
            e_ff   <= E_W'(L_W - 1);
         end
         OP_DIV_STEP: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - dsr_ff;
            end
            q_ff   <= {q_ff[QUOT_BITS-2:0], rem_ge};
            dsr_ff <= dsr_ff >> 1;
         end
         OP_NORM_STEP: begin
            // Shift a nibble at a time while the top nibble is empty, else one bit.
            if (v_ff[L_W-1 -: 4] == 4'd0) begin
               v_ff <= v_ff << 4;
               e_ff <= e_ff - E_W'(4);
            end else begin
               v_ff <= v_ff << 1;
               e_ff <= e_ff - E_W'(1);
            end
         end
         OP_MANT: begin
            m_ff <= v_ff[L_W-1 -: MANT_BITS];
            f_ff <= '0;
         end
         OP_SQ_STEP: begin
            // Squaring the mantissa doubles the log; an overflow past 2.0 is a one bit.
            if (sq_top[MANT_BITS]) begin
               m_ff <= sq_top[MANT_BITS:1];
            end else begin
               m_ff <= sq_top[MANT_BITS-1:0];
            end
            f_ff <= {f_ff[FRAC_BITS-2:0], sq_top[MANT_BITS]};
         end
         OP_LOAD_DEN: begin
            log_a_ff <= {e_ff, f_ff};
            v_ff     <= (log_den == '0) ? L_W'(1) : log_den;
            e_ff     <= E_W'(L_W - 1);
         end
         OP_DIFF: begin
            l_ff <= log_diff[LOG_W] ? '0 : log_diff[LOG_W-1:0];
         end
         OP_DBMUL: begin
            prod_ff <= P_W'(l_ff) * P_W'(DB_K);
         end
         OP_FINISH: begin
            rsp_high_ff <= snap_high_ff;
            rsp_low_ff  <= snap_low_ff;
            rsp_pct_ff  <= pct_val;
            rsp_db_ff   <= db_val;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_FINISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.publish   = publish;
   assign status.norm_done = v_ff[L_W-1];
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_high  = rsp_high_ff;
   assign rsp_low   = rsp_low_ff;
   assign rsp_pct   = rsp_pct_ff;
   assign rsp_db    = rsp_db_ff;

endmodule

### rtl/peak_to_peak_sound_level_top.sv
// Peak-to-peak sound level meter. Every word carries one ADC sample; a word
// with tlast set closes the sampling window, and if the publish interval has
// elapsed since the last result the held loudest window is published as raw
// maximum and minimum, a level in hundredths of a percent and a level in
// hundredths of a dB. A word that does not publish leaves the input ready
// for the next word. A publishing window close runs the 15-step restoring
// divider for the percentage, then the shared log2 unit twice, each pass
// normalizing a nibble at a time while the top nibble is empty and then a
// bit at a time, followed by 24 squaring steps. Input words are not taken
// while a publishing close is computed. A finished result waits in the
// output register while new samples are taken; the next publishing close
// holds in its last step until that register is free. Configuration must be
// written while idle.
// Depends on ppsl_pkg, ppsl_ctrl and ppsl_dp.
module peak_to_peak_sound_level_top import ppsl_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample, now_ms (from bit 0 up), zero padded
   input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   // window_last
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // raw_high, raw_low, level_percent_centi, level_db_centi (from bit 0 up)
   output logic [((2*SAMPLE_BITS+PCT_BITS+DB_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int RSP_W = ((2*SAMPLE_BITS+PCT_BITS+DB_BITS+7)/8)*8;

   cmd_type                cmd;
   status_type             status;
   logic [SAMPLE_BITS-1:0] rsp_high, rsp_low;
   logic [PCT_BITS-1:0]    rsp_pct;
   logic [DB_BITS-1:0]     rsp_db;

   ppsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ppsl_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .sample      (req_tdata[SAMPLE_BITS-1:0]),
      .window_last (req_tlast),
      .now_ms      (req_tdata[SAMPLE_BITS +: TIME_BITS]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_high    (rsp_high),
      .rsp_low     (rsp_low),
      .rsp_pct     (rsp_pct),
      .rsp_db      (rsp_db)
   );

   assign rsp_tdata = RSP_W'({rsp_db, rsp_pct, rsp_low, rsp_high});

endmodule

### rtl/ppsl_checker.sv
// Port-level checker for the sound level meter, bound to the top level.
// Uses the assertion macros of peak_to_peak_sound_level_top_assert.svh.
`include "peak_to_peak_sound_level_top_assert.svh"

module ppsl_checker #(
   parameter int RSP_W = 56
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // No result is pending right after reset.
   `PPSL_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result word keeps its value.
   `PPSL_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // A new result only appears at the end of a computation, when input was held off.
   `PPSL_ASSERT(a_rsp_after_busy, $rose(rsp_tvalid) |-> $past(!req_tready), "result without a window close computation")

   // A word that does not close a window never stalls the input.
   `PPSL_ASSERT(a_open_window_ready, req_tvalid && req_tready && !req_tlast |=> req_tready, "input stalled after an open-window word")

endmodule

bind peak_to_peak_sound_level_top ppsl_checker #(
   .RSP_W (RSP_W)
) u_ppsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
